// File: rtl/tifc_pkg.sv
// Shared types, constants and helper functions for the two-input fuzzy controller.
package tifc_pkg;

   localparam int NUM_SETS    = 5;
   localparam int DEG_BITS    = 16;
   localparam int DEG_W       = DEG_BITS + 1;
   localparam int DATA_W      = 16;
   localparam int BRK_REGS    = 5;
   localparam int CELL_BITS   = 3;
   localparam int ALL_CELLS   = 25;
   localparam int RULE_LOW_W  = 45;
   localparam int RULE_HIGH_W = 30;
   localparam int RULE_W      = RULE_LOW_W + RULE_HIGH_W;
   localparam int SET_IDX_W   = $clog2(NUM_SETS);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = RULE_LOW_W;

   // Arithmetic widths of the defuzzification path.
   localparam int DIFF_W = DATA_W + 1;
   localparam int MUL_W  = DEG_W + 1 + DIFF_W;
   localparam int CUT_W  = MUL_W + 2;
   localparam int P_W    = CUT_W - 1;
   localparam int PL_W   = 18;
   localparam int PH_W   = P_W - PL_W;
   localparam int PPL_W  = DEG_W + PL_W;
   localparam int PPH_W  = DEG_W + 1 + PH_W;
   localparam int NUMK_W = PPH_W + PL_W;
   localparam int NUM_W  = NUMK_W + $clog2(NUM_SETS);
   localparam int DEN_W  = DEG_W + $clog2(NUM_SETS);
   localparam int N2_W   = NUM_W + 1 - 8;
   localparam int U_W    = N2_W + 1;
   localparam int Q_W    = DATA_W + 1;
   localparam int R0_W   = U_W - Q_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_4     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFUZZ_MODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_LOW    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_HIGH   = 3'd7;

   localparam logic [DEG_W-1:0] DEG_ONE = {1'b1, {DEG_BITS{1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] first_value;
      logic signed [DATA_W-1:0] second_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] crisp_out;
      logic                     no_activation;
   } rsp_type;

   typedef logic [BRK_REGS-1:0][DATA_W-1:0] brk_array_type;
   typedef logic [NUM_SETS-1:0][DEG_W-1:0]  deg_vec_type;

   localparam brk_array_type BRK_RESET = {16'h0200, 16'h0100, 16'h0000, 16'hFF00, 16'hFE00};

   typedef struct packed {
      logic                 is_full;
      logic                 is_int;
      logic [SET_IDX_W-1:0] idx;
   } fuzz_ctrl_type;

   typedef struct packed {
      logic                     zero;
      logic signed [DATA_W-1:0] mom;
      logic [DEN_W-1:0]         den;
      logic                     neg;
      logic                     ovf;
   } side_type;

   // Breakpoints beyond the last register reuse the last one.
   function automatic logic signed [DATA_W-1:0] bp(brk_array_type b, int k);
      return signed'(b[(k < BRK_REGS) ? k : BRK_REGS - 1]);
   endfunction

   function automatic logic [CELL_BITS-1:0] rule_cell(logic [RULE_W-1:0] rules, int c);
      if (c < ALL_CELLS) begin
         return rules[c*CELL_BITS +: CELL_BITS];
      end
      return '0;
   endfunction

endpackage

// File: rtl/tifc_fuzz.sv
// Pipelined fuzzifier: one input value to the degrees of all triangular sets.
module tifc_fuzz (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [tifc_pkg::DATA_W-1:0]      x,
   input  tifc_pkg::brk_array_type                 brk,
   output logic                                    out_valid,
   output tifc_pkg::deg_vec_type                   deg
);

   localparam int DIV_W = tifc_pkg::DATA_W + 1;
   localparam int NB    = tifc_pkg::DEG_BITS;
   localparam int NS    = tifc_pkg::NUM_SETS;

   tifc_pkg::fuzz_ctrl_type ctrl_in;
   logic [DIV_W-1:0]        num_in;
   logic [DIV_W-1:0]        div_in;

   logic                    valid_ff [0:NB];
   tifc_pkg::fuzz_ctrl_type ctrl_ff  [0:NB];
   logic [NB-1:0]           q_ff     [0:NB];
   logic [DIV_W-1:0]        rem_ff   [0:NB-1];
   logic [DIV_W-1:0]        div_ff   [0:NB-1];

   tifc_pkg::deg_vec_type   deg_in;
   tifc_pkg::deg_vec_type   deg_ff;
   logic                    out_valid_ff;

   // Classification follows the priority: low shoulder, inner peak, high shoulder, interval.
   always_comb begin
      logic                    found;
      logic signed [DIV_W-1:0] x_e;
      logic signed [DIV_W-1:0] lo_e;
      logic signed [DIV_W-1:0] hi_e;
      found   = 1'b0;
      ctrl_in = '0;
      num_in  = '0;
      div_in  = '0;
      x_e     = DIV_W'(x);
      lo_e    = '0;
      hi_e    = '0;
      if (x <= tifc_pkg::bp(brk, 0)) begin
         ctrl_in.is_full = 1'b1;
         found           = 1'b1;
      end
      for (int k = 1; k < NS - 1; k++) begin
         if (!found && x == tifc_pkg::bp(brk, k)) begin
            ctrl_in.is_full = 1'b1;
            ctrl_in.idx     = tifc_pkg::SET_IDX_W'(k);
            found           = 1'b1;
         end
      end
      if (!found && x >= tifc_pkg::bp(brk, NS - 1)) begin
         ctrl_in.is_full = 1'b1;
         ctrl_in.idx     = tifc_pkg::SET_IDX_W'(NS - 1);
         found           = 1'b1;
      end
      for (int k = 0; k < NS - 1; k++) begin
         if (!found && x > tifc_pkg::bp(brk, k) && x < tifc_pkg::bp(brk, k + 1)) begin
            ctrl_in.is_int = 1'b1;
            ctrl_in.idx    = tifc_pkg::SET_IDX_W'(k);
            lo_e           = DIV_W'(tifc_pkg::bp(brk, k));
            hi_e           = DIV_W'(tifc_pkg::bp(brk, k + 1));
            num_in         = unsigned'(hi_e - x_e);
            div_in         = unsigned'(hi_e - lo_e);
            found          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      ctrl_ff[0] <= ctrl_in;
      q_ff[0]    <= '0;
      rem_ff[0]  <= num_in;
      div_ff[0]  <= div_in;
   end

   // Restoring division, one quotient bit per stage.
   for (genvar s = 1; s <= NB; s++) begin : g_div
      logic [DIV_W:0] trial;
      logic           ge;
      assign trial = {rem_ff[s-1], 1'b0};
      assign ge    = trial >= {1'b0, div_ff[s-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_ff[s-1];
         end
         ctrl_ff[s] <= ctrl_ff[s-1];
         q_ff[s]    <= {q_ff[s-1][NB-2:0], ge};
      end

      if (s < NB) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[s] <= ge ? DIV_W'(trial - {1'b0, div_ff[s-1]}) : DIV_W'(trial);
            div_ff[s] <= div_ff[s-1];
         end
      end
   end

   always_comb begin
      tifc_pkg::fuzz_ctrl_type c;
      logic [tifc_pkg::DEG_W-1:0] q_e;
      c   = ctrl_ff[NB];
      q_e = {1'b0, q_ff[NB]};
      for (int k = 0; k < NS; k++) begin
         deg_in[k] = '0;
         if (c.is_full && c.idx == tifc_pkg::SET_IDX_W'(k)) begin
            deg_in[k] = tifc_pkg::DEG_ONE;
         end
         if (c.is_int && c.idx == tifc_pkg::SET_IDX_W'(k)) begin
            deg_in[k] = q_e;
         end
         if (c.is_int && k > 0 && c.idx == tifc_pkg::SET_IDX_W'(k - 1)) begin
            deg_in[k] = tifc_pkg::DEG_ONE - q_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[NB];
      end
      deg_ff <= deg_in;
   end

   assign out_valid = out_valid_ff;
   assign deg       = deg_ff;

endmodule

// File: rtl/two_input_fuzzy_controller.sv
// Two-input max-min fuzzy controller with weighted-average or mean-of-maximum output.
// Throughput: one request per cycle; busy is never raised and nothing stalls.
// The two dividers (fuzzification and averaging) resolve one quotient bit per stage.
// Synchronous reset empties the pipeline and restores the default breakpoints,
// weighted-average mode and an all-zero rule table.
module two_input_fuzzy_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tifc_pkg::req_type                    req_data,
   input  logic                                 csr_we,
   input  logic [tifc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tifc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   output tifc_pkg::rsp_type                    rsp_data
);

   localparam int NS  = tifc_pkg::NUM_SETS;
   localparam int DW  = tifc_pkg::DEG_W;
   localparam int QW  = tifc_pkg::Q_W;

   // Configuration registers
   tifc_pkg::brk_array_type                  brk_ff;
   logic                                     mode_ff;
   logic [tifc_pkg::RULE_LOW_W-1:0]          rule_low_ff;
   logic [tifc_pkg::RULE_HIGH_W-1:0]         rule_high_ff;
   logic [tifc_pkg::RULE_W-1:0]              rules;

   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff       <= tifc_pkg::BRK_RESET;
         mode_ff      <= 1'b0;
         rule_low_ff  <= '0;
         rule_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tifc_pkg::CSR_BREAK_0:     brk_ff[0]    <= csr_wdata[tifc_pkg::DATA_W-1:0];
            tifc_pkg::CSR_BREAK_1:     brk_ff[1]    <= csr_wdata[tifc_pkg::DATA_W-1:0];
            tifc_pkg::CSR_BREAK_2:     brk_ff[2]    <= csr_wdata[tifc_pkg::DATA_W-1:0];
            tifc_pkg::CSR_BREAK_3:     brk_ff[3]    <= csr_wdata[tifc_pkg::DATA_W-1:0];
            tifc_pkg::CSR_BREAK_4:     brk_ff[4]    <= csr_wdata[tifc_pkg::DATA_W-1:0];
            tifc_pkg::CSR_DEFUZZ_MODE: mode_ff      <= csr_wdata[0];
            tifc_pkg::CSR_RULE_LOW:    rule_low_ff  <= csr_wdata[tifc_pkg::RULE_LOW_W-1:0];
            tifc_pkg::CSR_RULE_HIGH:   rule_high_ff <= csr_wdata[tifc_pkg::RULE_HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   assign rules = {rule_high_ff, rule_low_ff};
   assign busy  = 1'b0;

   // Request register
   logic              req_valid_ff;
   tifc_pkg::req_type req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
      req_ff <= req_data;
   end

   logic                  fz1_valid, fz2_valid, fz_valid;
   tifc_pkg::deg_vec_type d1, d2;

   tifc_fuzz u_fuzz_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .x         (req_ff.first_value),
      .brk       (brk_ff),
      .out_valid (fz1_valid),
      .deg       (d1)
   );

   tifc_fuzz u_fuzz_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .x         (req_ff.second_value),
      .brk       (brk_ff),
      .out_valid (fz2_valid),
      .deg       (d2)
   );

   assign fz_valid = fz1_valid & fz2_valid;

   // Rule strengths: min of the two degrees for every cell.
   logic          v1_ff;
   logic [DW-1:0] min_ff [NS][NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= fz_valid;
      end
      for (int i = 0; i < NS; i++) begin
         for (int j = 0; j < NS; j++) begin
            min_ff[i][j] <= (d1[i] < d2[j]) ? d1[i] : d2[j];
         end
      end
   end

   // Max per output set and rule row; cells naming no set never match.
   logic          v2_ff;
   logic [DW-1:0] rmax_in [NS][NS];
   logic [DW-1:0] rmax_ff [NS][NS];

   always_comb begin
      for (int c = 0; c < NS; c++) begin
         for (int i = 0; i < NS; i++) begin
            rmax_in[c][i] = '0;
            for (int j = 0; j < NS; j++) begin
               if (tifc_pkg::rule_cell(rules, i*NS + j) == tifc_pkg::CELL_BITS'(c) &&
                   min_ff[i][j] > rmax_in[c][i]) begin
                  rmax_in[c][i] = min_ff[i][j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      rmax_ff <= rmax_in;
   end

   logic          v3_ff;
   logic [DW-1:0] inf_in [NS];
   logic [DW-1:0] inf_ff [NS];

   always_comb begin
      for (int c = 0; c < NS; c++) begin
         inf_in[c] = '0;
         for (int i = 0; i < NS; i++) begin
            if (rmax_ff[c][i] > inf_in[c]) begin
               inf_in[c] = rmax_ff[c][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      inf_ff <= inf_in;
   end

   // Weight sum, strongest set and the alpha-cut slope products.
   logic                                  v4_ff;
   logic [tifc_pkg::DEN_W-1:0]            den_in, den4_ff;
   logic [tifc_pkg::SET_IDX_W-1:0]        best_in, best_ff;
   logic signed [tifc_pkg::MUL_W-1:0]     mlo_in [NS];
   logic signed [tifc_pkg::MUL_W-1:0]     mhi_in [NS];
   logic signed [tifc_pkg::MUL_W-1:0]     mlo_ff [NS];
   logic signed [tifc_pkg::MUL_W-1:0]     mhi_ff [NS];
   logic [DW-1:0]                         inf4_ff [NS];

   always_comb begin
      logic [DW-1:0]                     best_val;
      logic signed [tifc_pkg::MUL_W-1:0] a_e;
      logic signed [tifc_pkg::MUL_W-1:0] dlo;
      logic signed [tifc_pkg::MUL_W-1:0] dhi;
      den_in   = '0;
      best_in  = '0;
      best_val = inf_ff[0];
      a_e      = '0;
      dlo      = '0;
      dhi      = '0;
      for (int k = 0; k < NS; k++) begin
         den_in = den_in + tifc_pkg::DEN_W'(inf_ff[k]);
      end
      for (int k = 1; k < NS; k++) begin
         if (inf_ff[k] > best_val) begin
            best_val = inf_ff[k];
            best_in  = tifc_pkg::SET_IDX_W'(k);
         end
      end
      for (int k = 0; k < NS; k++) begin
         a_e       = tifc_pkg::MUL_W'(signed'({1'b0, inf_ff[k]}));
         mlo_in[k] = '0;
         mhi_in[k] = '0;
         if (k > 0) begin
            dlo = tifc_pkg::MUL_W'(tifc_pkg::bp(brk_ff, k))
                - tifc_pkg::MUL_W'(tifc_pkg::bp(brk_ff, k - 1));
            mlo_in[k] = a_e * dlo;
         end
         if (k < NS - 1) begin
            dhi = tifc_pkg::MUL_W'(tifc_pkg::bp(brk_ff, k + 1))
                - tifc_pkg::MUL_W'(tifc_pkg::bp(brk_ff, k));
            mhi_in[k] = a_e * dhi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      den4_ff <= den_in;
      best_ff <= best_in;
      mlo_ff  <= mlo_in;
      mhi_ff  <= mhi_in;
      inf4_ff <= inf_ff;
   end

   // Alpha-cut ends, representative points and the mean-of-maximum result.
   logic                                 v5_ff;
   logic signed [tifc_pkg::P_W-1:0]      p_in [NS];
   logic signed [tifc_pkg::P_W-1:0]      p_ff [NS];
   logic [DW-1:0]                        inf5_ff [NS];
   tifc_pkg::side_type                   side5_in, side5_ff;

   always_comb begin
      logic signed [tifc_pkg::CUT_W-1:0] lo;
      logic signed [tifc_pkg::CUT_W-1:0] hi;
      logic signed [tifc_pkg::CUT_W-1:0] twice;
      logic signed [tifc_pkg::P_W-1:0]   pm;
      logic signed [tifc_pkg::P_W-1:0]   t;
      lo    = '0;
      hi    = '0;
      twice = '0;
      pm    = '0;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            lo = tifc_pkg::CUT_W'(tifc_pkg::bp(brk_ff, 0)) <<< tifc_pkg::DEG_BITS;
         end else begin
            lo = (tifc_pkg::CUT_W'(tifc_pkg::bp(brk_ff, k - 1)) <<< tifc_pkg::DEG_BITS)
               + tifc_pkg::CUT_W'(mlo_ff[k]);
         end
         if (k == NS - 1) begin
            hi = tifc_pkg::CUT_W'(tifc_pkg::bp(brk_ff, k)) <<< tifc_pkg::DEG_BITS;
         end else begin
            hi = (tifc_pkg::CUT_W'(tifc_pkg::bp(brk_ff, k + 1)) <<< tifc_pkg::DEG_BITS)
               - tifc_pkg::CUT_W'(mhi_ff[k]);
         end
         twice = (lo + hi) >>> 1;
         if (k == 0) begin
            p_in[k] = tifc_pkg::P_W'(hi);
         end else if (k == NS - 1) begin
            p_in[k] = tifc_pkg::P_W'(lo);
         end else begin
            p_in[k] = tifc_pkg::P_W'(twice);
         end
         if (best_ff == tifc_pkg::SET_IDX_W'(k)) begin
            pm = tifc_pkg::P_W'(twice);
         end
      end
      t = (pm + tifc_pkg::P_W'(128)) >>> 8;
      side5_in      = '0;
      side5_in.den  = den4_ff;
      side5_in.zero = (den4_ff == '0);
      if (t > tifc_pkg::P_W'(32767)) begin
         side5_in.mom = 16'sh7FFF;
      end else if (t < tifc_pkg::P_W'(-32768)) begin
         side5_in.mom = 16'sh8000;
      end else begin
         side5_in.mom = t[tifc_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      p_ff     <= p_in;
      inf5_ff  <= inf4_ff;
      side5_ff <= side5_in;
   end

   // Weighted sum: each product is split into two narrower partial products.
   logic                                  v6_ff, v7_ff, v8_ff, v9_ff;
   logic [tifc_pkg::PPL_W-1:0]            ppl_ff [NS];
   logic signed [tifc_pkg::PPH_W-1:0]     pph_ff [NS];
   logic signed [tifc_pkg::NUMK_W-1:0]    numk_ff [NS];
   logic signed [tifc_pkg::NUM_W-1:0]     num_ff;
   logic signed [tifc_pkg::NUM_W-1:0]     num_in;
   logic signed [tifc_pkg::N2_W-1:0]      n2_ff;
   logic signed [tifc_pkg::NUM_W:0]       n2_sum;
   tifc_pkg::side_type                    side6_ff, side7_ff, side8_ff, side9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      for (int k = 0; k < NS; k++) begin
         ppl_ff[k] <= tifc_pkg::PPL_W'(inf5_ff[k])
                    * tifc_pkg::PPL_W'(p_ff[k][tifc_pkg::PL_W-1:0]);
         pph_ff[k] <= tifc_pkg::PPH_W'(signed'({1'b0, inf5_ff[k]}))
                    * tifc_pkg::PPH_W'(signed'(p_ff[k][tifc_pkg::P_W-1:tifc_pkg::PL_W]));
      end
      side6_ff <= side5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      for (int k = 0; k < NS; k++) begin
         numk_ff[k] <= (tifc_pkg::NUMK_W'(pph_ff[k]) <<< tifc_pkg::PL_W)
                     + tifc_pkg::NUMK_W'(signed'({1'b0, ppl_ff[k]}));
      end
      side7_ff <= side6_ff;
   end

   always_comb begin
      num_in = '0;
      for (int k = 0; k < NS; k++) begin
         num_in = num_in + tifc_pkg::NUM_W'(numk_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
      num_ff   <= num_in;
      side8_ff <= side7_ff;
   end

   // floor((num + 128*den) / (256*den)) is taken as floor(floor((num + 128*den) / 256) / den).
   assign n2_sum = (tifc_pkg::NUM_W+1)'(num_ff)
                 + ((tifc_pkg::NUM_W+1)'(signed'({1'b0, side8_ff.den})) <<< 7);

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      n2_ff    <= tifc_pkg::N2_W'(n2_sum >>> 8);
      side9_ff <= side8_ff;
   end

   // Divider set-up: a negative dividend is divided as a ceiling of its magnitude.
   logic                              dv_valid_ff [0:QW];
   tifc_pkg::side_type                dv_side_ff  [0:QW];
   logic [tifc_pkg::DEN_W-1:0]        dv_rem_ff   [0:QW-1];
   logic [QW-1:0]                     dv_low_ff   [0:QW-1];
   logic [QW-1:0]                     dv_q_ff     [0:QW];
   logic [tifc_pkg::U_W-1:0]          u_in;
   logic [tifc_pkg::R0_W-1:0]         r0;
   tifc_pkg::side_type                side10_in;

   always_comb begin
      logic signed [tifc_pkg::U_W-1:0] u_s;
      u_s = tifc_pkg::U_W'(n2_ff);
      if (n2_ff < 0) begin
         u_s = -u_s + tifc_pkg::U_W'(signed'({1'b0, side9_ff.den}))
             - tifc_pkg::U_W'(1);
      end
      u_in          = unsigned'(u_s);
      r0            = u_in[tifc_pkg::U_W-1:QW];
      side10_in     = side9_ff;
      side10_in.neg = (n2_ff < 0);
      side10_in.ovf = (r0 >= tifc_pkg::R0_W'(side9_ff.den));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= v9_ff;
      end
      dv_side_ff[0] <= side10_in;
      dv_rem_ff[0]  <= side10_in.ovf ? '0 : r0[tifc_pkg::DEN_W-1:0];
      dv_low_ff[0]  <= u_in[QW-1:0];
      dv_q_ff[0]    <= '0;
   end

   for (genvar s = 1; s <= QW; s++) begin : g_avg_div
      logic [tifc_pkg::DEN_W:0] trial;
      logic                     ge;
      assign trial = {dv_rem_ff[s-1], dv_low_ff[s-1][QW-1]};
      assign ge    = trial >= {1'b0, dv_side_ff[s-1].den};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s] <= 1'b0;
         end else begin
            dv_valid_ff[s] <= dv_valid_ff[s-1];
         end
         dv_side_ff[s] <= dv_side_ff[s-1];
         dv_q_ff[s]    <= {dv_q_ff[s-1][QW-2:0], ge};
      end

      if (s < QW) begin : g_rem
         always_ff @(posedge clock) begin
            dv_rem_ff[s] <= ge ? tifc_pkg::DEN_W'(trial - {1'b0, dv_side_ff[s-1].den})
                               : tifc_pkg::DEN_W'(trial);
            dv_low_ff[s] <= {dv_low_ff[s-1][QW-2:0], 1'b0};
         end
      end
   end

   // Result selection and saturation
   tifc_pkg::rsp_type rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      tifc_pkg::side_type sd;
      logic [QW-1:0]      q;
      logic [QW-1:0]      q_neg;
      sd     = dv_side_ff[QW];
      q      = dv_q_ff[QW];
      q_neg  = QW'(0) - q;
      rsp_in = '0;
      if (sd.zero) begin
         rsp_in.no_activation = 1'b1;
      end else if (mode_ff) begin
         rsp_in.crisp_out = sd.mom;
      end else if (!sd.neg) begin
         if (sd.ovf || q > QW'(32767)) begin
            rsp_in.crisp_out = 16'sh7FFF;
         end else begin
            rsp_in.crisp_out = signed'(q[tifc_pkg::DATA_W-1:0]);
         end
      end else begin
         if (sd.ovf || q > QW'(32768)) begin
            rsp_in.crisp_out = 16'sh8000;
         end else begin
            rsp_in.crisp_out = signed'(q_neg[tifc_pkg::DATA_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid_ff[QW];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
